>>> src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ASSERT_PROP(lbl, clk, rst_n, !(cond), msg)

`endif

>>> src/pfss_pkg.sv
package pfss_pkg;

	localparam int QUEUE_DEPTH = 16;

	// action codes
	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_POP   = 2'd1;
	localparam logic [1:0] ACT_DEL   = 2'd2;
	localparam logic [1:0] ACT_QUERY = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] entry_pid;
		logic [15:0] entry_service;
	} req_t;

	typedef struct packed {
		logic [15:0] front_pid;
		logic [15:0] front_service;
		logic [15:0] shortest_pid;
		logic [15:0] shortest_service;
		logic [4:0]  entry_count;
		logic        is_empty;
		logic [1:0]  status;
	} rsp_t;

	// operation broadcast to every cell during a walk
	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] pid;
		logic [15:0] svc;
	} ctl_t;

	// token handed from cell to cell, one cell per cycle
	typedef struct packed {
		logic        active;
		logic        found;
		logic        min_vld;
		logic [15:0] min_pid;
		logic [15:0] min_svc;
	} wave_t;

endpackage

>>> src/pfss_chan_if.sv
interface pfss_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> src/pfss_cell.sv
module pfss_cell #(
	parameter int Idx  = 0,
	parameter int CntW = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pfss_pkg::ctl_t   ctl,
	input  logic [CntW-1:0]  count,
	input  pfss_pkg::wave_t  wave_in,
	output pfss_pkg::wave_t  wave_out,
	input  logic [15:0]      nbr_pid,
	input  logic [15:0]      nbr_svc,
	output logic [15:0]      pid,
	output logic [15:0]      svc
);

	localparam logic [CntW:0] IdxW = (CntW+1)'(Idx);

	logic [15:0]     pid_q, svc_q;
	logic [15:0]     pid_n, svc_n;
	pfss_pkg::wave_t wave_q, wave_n;
	logic            here_vld, nxt_vld, is_match, is_load, found_out, vld_new, take;

	always_comb begin
		here_vld = IdxW < {1'b0, count};
		nxt_vld  = (IdxW + 1'b1) < {1'b0, count};
		is_load  = (ctl.op == pfss_pkg::ACT_PUSH) && (IdxW == {1'b0, count});
		case (ctl.op)
			pfss_pkg::ACT_DEL: is_match = here_vld && (pid_q == ctl.pid);
			pfss_pkg::ACT_POP: is_match = here_vld && (IdxW == '0);
			default:           is_match = 1'b0;
		endcase
		found_out = wave_in.found || is_match;
		// close the gap: take the right neighbor, which the token has not reached yet
		if (found_out) begin
			pid_n = nbr_pid;
			svc_n = nbr_svc;
		end else if (is_load) begin
			pid_n = ctl.pid;
			svc_n = ctl.svc;
		end else begin
			pid_n = pid_q;
			svc_n = svc_q;
		end
		vld_new = found_out ? nxt_vld : (here_vld || is_load);
		take    = vld_new && (!wave_in.min_vld || (svc_n < wave_in.min_svc));
		wave_n         = wave_in;
		wave_n.found   = found_out;
		if (take) begin
			wave_n.min_vld = 1'b1;
			wave_n.min_pid = pid_n;
			wave_n.min_svc = svc_n;
		end
	end

	always_ff @(posedge clk) begin
		if (wave_in.active) begin
			pid_q <= pid_n;
			svc_q <= svc_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= '0;
		end else begin
			wave_q <= wave_in.active ? wave_n : '0;
		end
	end

	assign wave_out = wave_q;
	assign pid      = pid_q;
	assign svc      = svc_q;

endmodule

>>> src/process_fifo_with_shortest_select.sv
// The request is latched on accept, the token walks every cell, then the result is registered.
// Requests are taken only in S_IDLE, one at a time; a token walks the cell row one cell a cycle.
// A result that waits at the output holds the walk's end until it is taken.
// Reset: arst_n clears the entry count, the control state and the output valid;
// the entry cells themselves are not cleared, as only held entries are ever read.
`include "assert_macros.svh"

module process_fifo_with_shortest_select #(
	parameter int QUEUE_DEPTH = pfss_pkg::QUEUE_DEPTH
) (
	input logic         clk,
	input logic         arst_n,
	pfss_chan_if.sink   req,
	pfss_chan_if.source rsp
);

	localparam int CntW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t          state_q;
	pfss_pkg::ctl_t  ctl_q;
	logic [CntW-1:0] count_q;
	logic            start_q;
	logic [1:0]      status_q;
	logic            min_vld_q;
	logic [15:0]     min_pid_q, min_svc_q;
	logic            out_vld_q;
	pfss_pkg::rsp_t  out_q;

	logic            accept;
	logic            emit;
	pfss_pkg::wave_t wave [QUEUE_DEPTH+1];
	logic [15:0]     cell_pid [QUEUE_DEPTH];
	logic [15:0]     cell_svc [QUEUE_DEPTH];
	pfss_pkg::wave_t wave_last;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign emit      = (state_q == S_EMIT) && (!out_vld_q || rsp.ready);
	assign wave_last = wave[QUEUE_DEPTH];

	// Launch the token into cell 0 in the cycle after accept, once the operation is latched.
	always_comb begin
		wave[0]        = '0;
		wave[0].active = start_q;
	end

	// Row of cells: cell k holds queue position k. The token passes left to right,
	// applying the operation and carrying the running minimum of the new contents.
	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		logic [15:0] nbr_pid, nbr_svc;
		if (k == QUEUE_DEPTH - 1) begin : g_tail
			assign nbr_pid = '0;
			assign nbr_svc = '0;
		end else begin : g_mid
			assign nbr_pid = cell_pid[k+1];
			assign nbr_svc = cell_svc[k+1];
		end
		pfss_cell #(
			.Idx  (k),
			.CntW (CntW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl_q),
			.count    (count_q),
			.wave_in  (wave[k]),
			.wave_out (wave[k+1]),
			.nbr_pid  (nbr_pid),
			.nbr_svc  (nbr_svc),
			.pid      (cell_pid[k]),
			.svc      (cell_svc[k])
		);
	end

	// Latch the operation on accept; it stays put for the whole walk.
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_q.op  <= req.data.action;
			ctl_q.pid <= req.data.entry_pid;
			ctl_q.svc <= req.data.entry_service;
		end
	end

	// Capture the minimum when the token leaves the last cell.
	always_ff @(posedge clk) begin
		if (wave_last.active) begin
			min_vld_q <= wave_last.min_vld;
			min_pid_q <= wave_last.min_pid;
			min_svc_q <= wave_last.min_svc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			start_q  <= 1'b0;
			count_q  <= '0;
			status_q <= pfss_pkg::ST_OK;
		end else begin
			start_q <= accept;
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_WALK;
				end
				S_WALK: begin
					// Settle count and status from the old count and whether a match was found.
					if (wave_last.active) begin
						state_q <= S_EMIT;
						case (ctl_q.op)
							pfss_pkg::ACT_PUSH: begin
								if (count_q == DepthC) begin
									status_q <= pfss_pkg::ST_FULL;
								end else begin
									status_q <= pfss_pkg::ST_OK;
									count_q  <= count_q + 1'b1;
								end
							end
							pfss_pkg::ACT_POP: begin
								if (wave_last.found) begin
									status_q <= pfss_pkg::ST_OK;
									count_q  <= count_q - 1'b1;
								end else begin
									status_q <= pfss_pkg::ST_EMPTY;
								end
							end
							pfss_pkg::ACT_DEL: begin
								if (wave_last.found) begin
									status_q <= pfss_pkg::ST_OK;
									count_q  <= count_q - 1'b1;
								end else begin
									status_q <= pfss_pkg::ST_NOT_FOUND;
								end
							end
							default: status_q <= pfss_pkg::ST_OK;
						endcase
					end
				end
				S_EMIT: begin
					if (emit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register: holds the result until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.front_pid        <= (count_q != '0) ? cell_pid[0] : 16'd0;
			out_q.front_service    <= (count_q != '0) ? cell_svc[0] : 16'd0;
			out_q.shortest_pid     <= min_vld_q ? min_pid_q : 16'd0;
			out_q.shortest_service <= min_vld_q ? min_svc_q : 16'd0;
			out_q.entry_count      <= 5'(count_q);
			out_q.is_empty         <= (count_q == '0);
			out_q.status           <= status_q;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > DepthC, "entry count above depth")
	`ASSERT_PROP(a_wave_in_walk, clk, arst_n, wave_last.active |-> (state_q == S_WALK),
		"token exit outside walk")
	`ASSERT_PROP(a_accept_walk, clk, arst_n, accept |=> (state_q == S_WALK),
		"accept did not start a walk")
	`ASSERT_PROP(a_empty_zero, clk, arst_n, (rsp.valid && rsp.data.is_empty) |->
		(rsp.data.front_pid == 16'd0 && rsp.data.shortest_service == 16'd0),
		"empty result with nonzero entry")

endmodule
